[rtl/core/deq_pkg.sv]
package deq_pkg;

    localparam int NUM_QUEUES    = 8;
    localparam int CAPACITY      = 64;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int HANDLE_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int QIW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HG_W     = $clog2(NUM_QUEUES + 1);
    localparam int DEPTH    = NUM_QUEUES * CAPACITY;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W  = KEY_W + PAYLOAD_WIDTH;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_ADD      = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_COPY     = 3'd3,
        OP_DEL_MIN  = 3'd4,
        OP_DEL_MAX  = 3'd5,
        OP_DESTROY  = 3'd6,
        OP_IS_EMPTY = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_HANDLE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_INIT,
        S_SHIFT,
        S_DEL_DONE,
        S_COPY,
        S_COPY_DONE,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_SCAN,
        CMD_SHIFT_INIT,
        CMD_SHIFT,
        CMD_DEL_DONE,
        CMD_COPY,
        CMD_COPY_DONE,
        CMD_POST
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic need_scan;
        logic need_copy;
        logic scan_last;
        logic stream_done;
    } dp_status_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic                has_value;
        logic [HANDLE_W-1:0] new_handle;
        logic                is_empty;
        status_t             status;
    } result_t;

endpackage

[rtl/core/deq_req_if.sv]
interface deq_req_if;
    import deq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              operation;
    logic [HANDLE_W-1:0]     queue_handle;
    logic [HANDLE_W-1:0]     source_handle;
    logic signed [KEY_W-1:0] priority_key;
    logic [31:0]             payload;

    modport source (output valid, operation, queue_handle, source_handle, priority_key,
                    payload, input ready);
    modport sink (input valid, operation, queue_handle, source_handle, priority_key,
                  payload, output ready);
endinterface

[rtl/core/deq_rsp_if.sv]
interface deq_rsp_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value_out;
    logic                has_value;
    logic [HANDLE_W-1:0] new_handle;
    logic                is_empty;
    logic [2:0]          status;

    modport source (output valid, value_out, has_value, new_handle, is_empty, status,
                    input ready);
    modport sink (input valid, value_out, has_value, new_handle, is_empty, status,
                  output ready);
endinterface

[rtl/core/deq_ram.sv]
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/deq_ctrl.sv]
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  deq_pkg::dp_status_t st,
    output deq_pkg::cmd_t     cmd,
    output logic              in_ready
);
    import deq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.need_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (st.need_copy)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_SHIFT_INIT;
                end
            end
            S_SHIFT_INIT: state_next = S_SHIFT;
            S_SHIFT:
            begin
                if (st.stream_done)
                begin
                    state_next = S_DEL_DONE;
                end
            end
            S_DEL_DONE: state_next = S_RESP;
            S_COPY:
            begin
                if (st.stream_done)
                begin
                    state_next = S_COPY_DONE;
                end
            end
            S_COPY_DONE: state_next = S_RESP;
            S_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = CMD_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (st.in_valid)
                begin
                    cmd = CMD_LOAD;
                end
            end
            S_DECODE:     cmd = CMD_DECODE;
            S_SCAN:       cmd = CMD_SCAN;
            S_SHIFT_INIT: cmd = CMD_SHIFT_INIT;
            S_SHIFT:      cmd = CMD_SHIFT;
            S_DEL_DONE:   cmd = CMD_DEL_DONE;
            S_COPY:       cmd = CMD_COPY;
            S_COPY_DONE:  cmd = CMD_COPY_DONE;
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd = CMD_POST;
                end
            end
            default: cmd = CMD_NONE;
        endcase
    end
endmodule

[rtl/core/deq_datapath.sv]
module deq_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  deq_pkg::cmd_t                  cmd,
    output deq_pkg::dp_status_t            st,
    input  logic                           in_valid,
    input  logic [2:0]                     in_operation,
    input  logic [deq_pkg::HANDLE_W-1:0]   in_queue_handle,
    input  logic [deq_pkg::HANDLE_W-1:0]   in_source_handle,
    input  logic signed [deq_pkg::KEY_W-1:0] in_priority_key,
    input  logic [31:0]                    in_payload,
    input  logic                           out_ready,
    output logic                           out_valid,
    output deq_pkg::result_t               out_result
);
    import deq_pkg::*;

    op_t                     op_reg;
    logic [HANDLE_W-1:0]     qh_reg, sh_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;

    logic [CNT_W-1:0] fill_reg [NUM_QUEUES];
    logic             alive_reg [NUM_QUEUES];
    logic [HG_W-1:0]  hg_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_pos_reg;
    logic             out_valid_reg;

    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [KEY_W-1:0]  best_key_reg;
    logic [PAYLOAD_WIDTH-1:0] best_pay_reg;
    result_t                  res_reg, res_next;
    result_t                  out_reg;

    logic [QIW-1:0]  qh_i, sh_i, rq_i, hg_i;
    logic            h_ok, s_ok, is_copy, issue, take;
    logic [CNT_W-1:0] fsel;
    logic            ram_we;
    logic [ADDR_W-1:0] raddr, waddr, wbase;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic signed [KEY_W-1:0]  rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;

    assign qh_i    = qh_reg[QIW-1:0];
    assign sh_i    = sh_reg[QIW-1:0];
    assign hg_i    = hg_reg[QIW-1:0];
    assign h_ok    = (int'(qh_reg) < NUM_QUEUES) && alive_reg[qh_i];
    assign s_ok    = (int'(sh_reg) < NUM_QUEUES) && alive_reg[sh_i];
    assign is_copy = (op_reg == OP_COPY);
    assign fsel    = fill_reg[is_copy ? sh_i : qh_i];

    assign issue = ((cmd == CMD_SCAN) || (cmd == CMD_SHIFT) || (cmd == CMD_COPY))
                   && (idx_reg < n_reg);
    assign rq_i  = (cmd == CMD_COPY) ? sh_i : qh_i;
    assign raddr = ADDR_W'(rq_i) * ADDR_W'(CAPACITY) + ADDR_W'(idx_reg);
    assign wbase = ADDR_W'(qh_i) * ADDR_W'(CAPACITY);

    assign rd_key = signed'(rdata[ENTRY_W-1 -: KEY_W]);
    assign rd_pay = rdata[PAYLOAD_WIDTH-1:0];
    // first entry seeds the search; ties keep the oldest for min, newest for max
    assign take = (rd_pos_reg == '0) ||
                  ((op_reg == OP_DEL_MIN) ? (rd_key < best_key_reg)
                                          : (rd_key >= best_key_reg));

    always_comb
    begin
        ram_we = 1'b0;
        waddr  = wbase + ADDR_W'(fsel);
        wdata  = {key_reg, pay_reg};
        case (cmd)
            CMD_DECODE:
            begin
                ram_we = (op_reg == OP_ADD) && h_ok && (int'(fsel) < CAPACITY);
            end
            CMD_SHIFT:
            begin
                ram_we = rd_valid_reg;
                waddr  = wbase + ADDR_W'(rd_pos_reg) - ADDR_W'(1);
                wdata  = rdata;
            end
            CMD_COPY:
            begin
                ram_we = rd_valid_reg;
                waddr  = wbase + ADDR_W'(rd_pos_reg);
                wdata  = rdata;
            end
            default: ram_we = 1'b0;
        endcase
    end

    deq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign st.in_valid    = in_valid;
    assign st.out_free    = !out_valid_reg || out_ready;
    assign st.need_scan   = ((op_reg == OP_DEL_MIN) || (op_reg == OP_DEL_MAX)) && h_ok
                            && (fsel != '0);
    assign st.need_copy   = is_copy && h_ok && s_ok && (qh_reg != sh_reg);
    assign st.scan_last   = rd_valid_reg && (CNT_W'(rd_pos_reg) == n_reg - CNT_W'(1));
    assign st.stream_done = (idx_reg >= n_reg) && !rd_valid_reg;

    always_comb
    begin
        res_next = res_reg;
        case (cmd)
            CMD_DECODE:
            begin
                res_next = '0;
                res_next.status = ST_OK;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (int'(hg_reg) >= NUM_QUEUES)
                        begin
                            res_next.status = ST_NO_HANDLE;
                        end
                        else
                        begin
                            res_next.new_handle = HANDLE_W'(hg_reg);
                        end
                    end
                    OP_COPY:
                    begin
                        if (!h_ok || !s_ok)
                        begin
                            res_next.status = ST_BAD_HANDLE;
                        end
                    end
                    OP_IS_EMPTY:
                    begin
                        res_next.is_empty = !h_ok || (fsel == '0);
                        res_next.status   = h_ok ? ST_OK : ST_BAD_HANDLE;
                    end
                    default:
                    begin
                        if (!h_ok)
                        begin
                            res_next.status = ST_BAD_HANDLE;
                        end
                        else if ((op_reg == OP_ADD) && (int'(fsel) >= CAPACITY))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else if (((op_reg == OP_DEL_MIN) || (op_reg == OP_DEL_MAX))
                                 && (fsel == '0))
                        begin
                            res_next.status = ST_EMPTY;
                        end
                    end
                endcase
            end
            CMD_DEL_DONE:
            begin
                res_next.value_out = VALUE_W'(best_pay_reg);
                res_next.has_value = 1'b1;
            end
            default: res_next = res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                fill_reg[i]  <= '0;
                alive_reg[i] <= 1'b0;
            end
            hg_reg        <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // no read is issued on load or shift start, so this drops there
            rd_valid_reg <= issue;
            if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            case (cmd)
                CMD_LOAD:
                begin
                    idx_reg <= '0;
                end
                CMD_DECODE:
                begin
                    case (op_reg)
                        OP_CREATE:
                        begin
                            if (int'(hg_reg) < NUM_QUEUES)
                            begin
                                alive_reg[hg_i] <= 1'b1;
                                fill_reg[hg_i]  <= '0;
                                hg_reg          <= hg_reg + HG_W'(1);
                            end
                        end
                        OP_ADD:
                        begin
                            if (h_ok && (int'(fsel) < CAPACITY))
                            begin
                                fill_reg[qh_i] <= fsel + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (h_ok)
                            begin
                                fill_reg[qh_i] <= '0;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (h_ok)
                            begin
                                alive_reg[qh_i] <= 1'b0;
                                fill_reg[qh_i]  <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_SHIFT_INIT:
                begin
                    idx_reg <= CNT_W'(best_idx_reg) + CNT_W'(1);
                end
                CMD_DEL_DONE:  fill_reg[qh_i] <= n_reg - CNT_W'(1);
                CMD_COPY_DONE: fill_reg[qh_i] <= n_reg;
                default: ;
            endcase
            if (cmd == CMD_POST)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd == CMD_LOAD)
        begin
            op_reg  <= op_t'(in_operation);
            qh_reg  <= in_queue_handle;
            sh_reg  <= in_source_handle;
            key_reg <= in_priority_key;
            pay_reg <= PAYLOAD_WIDTH'(in_payload);
        end
        if (cmd == CMD_DECODE)
        begin
            n_reg <= fsel;
        end
        rd_pos_reg <= idx_reg[IDX_W-1:0];
        if ((cmd == CMD_SCAN) && rd_valid_reg && take)
        begin
            best_idx_reg <= rd_pos_reg;
            best_key_reg <= rd_key;
            best_pay_reg <= rd_pay;
        end
        if (cmd == CMD_POST)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
endmodule

[rtl/core/double_ended_priority_queue_unit.sv]
// Bank of handle-addressed double-ended priority queues.
// request carries one command word: operation, queue and source handles,
// a signed Q16.16 key and a payload. response returns one word per command:
// removed payload, has_value, new handle, empty flag and status code.
// A command is taken when request.valid and request.ready are both high;
// ready is high only while the unit is idle, so one command is in flight.
// From acceptance to response.valid, each command passes decode and then:
//   create, add, clear, destroy, is_empty, failed commands: the response state
//   delete_min / delete_max: search, shift start, shift, delete done, response
//   copy: copy, copy done, response
// A delete reads the entry store through its single read port: one
// entry per cycle through the search, then one per cycle to close the gap.
// The response sits in an output register; the next command may be accepted
// while it waits, but its own response holds until the previous one is taken.
// Reset empties every queue and returns the handle counter to zero; stored
// entries are not cleared, since only slots below a queue's fill are read.
module double_ended_priority_queue_unit (
    input logic      clk,
    input logic      rst_n,
    deq_req_if.sink  request,
    deq_rsp_if.source response
);
    import deq_pkg::*;

    cmd_t       cmd;
    dp_status_t st;
    result_t    result;

    deq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .st      (st),
        .cmd     (cmd),
        .in_ready(request.ready)
    );

    deq_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_valid        (request.valid),
        .in_operation    (request.operation),
        .in_queue_handle (request.queue_handle),
        .in_source_handle(request.source_handle),
        .in_priority_key (request.priority_key),
        .in_payload      (request.payload),
        .out_ready       (response.ready),
        .out_valid       (response.valid),
        .out_result      (result)
    );

    assign response.value_out  = result.value_out;
    assign response.has_value  = result.has_value;
    assign response.new_handle = result.new_handle;
    assign response.is_empty   = result.is_empty;
    assign response.status     = result.status;
endmodule

[rtl/core/deq_checker.sv]
module deq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [deq_pkg::VALUE_W-1:0] value_out,
    input logic                        has_value,
    input logic [deq_pkg::HANDLE_W-1:0] new_handle,
    input logic                        is_empty,
    input logic [2:0]                  status
);
    import deq_pkg::*;

    // one command in flight: ready drops after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while another in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && has_value |-> status == ST_OK)
        else $error("payload returned with failing status");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_value |-> value_out == '0)
        else $error("value without has_value");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> !has_value && new_handle == '0
                                  && (status == ST_OK || status == ST_BAD_HANDLE))
        else $error("empty flag mixed with other results");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("stalled response changed");
endmodule

bind double_ended_priority_queue_unit deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .value_out (response.value_out),
    .has_value (response.has_value),
    .new_handle(response.new_handle),
    .is_empty  (response.is_empty),
    .status    (response.status)
);
